/* sv/dwepd_pkg.sv */
package dwepd_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned DistW  = 16;
  localparam int unsigned GainW  = 16;
  localparam int unsigned LimW   = 32;
  localparam int unsigned DutyW  = 8;
  localparam int unsigned MagW   = DistW + 1;
  localparam int unsigned ProdW  = MagW + GainW;

  // A count change above this is taken as a wrap of the 16-bit counter.
  localparam logic [CountW-1:0] WrapLimit = CountW'(10000);
  // The product must reach 0.01 in Q16: p * 100 < 65536 holds exactly for p < 656.
  localparam logic [ProdW-1:0] MinProduct = ProdW'(656);

  localparam logic [GainW-1:0] GainReset  = GainW'(6554);
  localparam logic [LimW-1:0]  LimAReset  = 32'h1815_1711;
  localparam logic [LimW-1:0]  LimBReset  = 32'h2116_1E15;

  typedef enum logic [1:0] {
    CFG_GAIN_A   = 2'd0,
    CFG_GAIN_B   = 2'd1,
    CFG_LIMITS_A = 2'd2,
    CFG_LIMITS_B = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    HEAD_NONE = 2'd0,
    HEAD_FWD  = 2'd1,
    HEAD_BACK = 2'd2,
    HEAD_RSVD = 2'd3
  } heading_e;

  // Per-wheel values carried from the state update to the duty stage.
  typedef struct packed {
    logic [MagW-1:0]  mag;
    logic [GainW-1:0] gain;
    logic [DutyW-1:0] lo;
    logic [DutyW-1:0] hi;
  } wheel_stage_t;

  typedef struct packed {
    logic                    load;
    wheel_stage_t            wa;
    wheel_stage_t            wb;
    heading_e                dir_a;
    heading_e                dir_b;
    logic signed [DistW-1:0] left_a;
    logic signed [DistW-1:0] left_b;
    logic                    arrived;
  } mid_stage_t;

endpackage

/* sv/dual_wheel_encoder_position_drive_core.sv */
// A result passes the middle stage register and then the output register on its way out.
// Throughput: one transaction per cycle while m_axis_tready is high; the state update sits in
// the first stage and the 17x16 duty multiply with its limit compares in the second.
// Reset (rst_ni low, asynchronous): remaining distances, previous counts and headings clear,
// gains and limits return to their defaults and both pipeline stages empty.
module dual_wheel_encoder_position_drive_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave side. tdata: count_a, count_b, target_a, target_b from the lowest bit up.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  // tuser: action (0 control tick, 1 load targets).
  input  logic        s_axis_tuser,
  // Master side. tdata: duty_a, duty_b, dir_a, dir_b, idle_a, idle_b, left_a, left_b,
  // arrived from the lowest bit up, then one zero pad bit.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned CountW = dwepd_pkg::CountW;
  localparam int unsigned DistW  = dwepd_pkg::DistW;
  localparam int unsigned GainW  = dwepd_pkg::GainW;
  localparam int unsigned LimW   = dwepd_pkg::LimW;
  localparam int unsigned DutyW  = dwepd_pkg::DutyW;
  localparam int unsigned MagW   = dwepd_pkg::MagW;
  localparam int unsigned ProdW  = dwepd_pkg::ProdW;

  // Result of one wheel's state update.
  typedef struct packed {
    logic signed [DistW-1:0] rem;
    dwepd_pkg::heading_e     head;
    dwepd_pkg::wheel_stage_t stage;
  } wheel_upd_t;

  // Configuration registers.
  logic [GainW-1:0] gain_a_q, gain_b_q;
  logic [LimW-1:0]  limits_a_q, limits_b_q;

  // Architectural state.
  logic signed [DistW-1:0] remaining_a_q, remaining_b_q;
  logic [CountW-1:0]       prev_count_a_q, prev_count_b_q;
  dwepd_pkg::heading_e     heading_a_q, heading_b_q;

  // Pipeline registers.
  logic                  mid_valid_q;
  dwepd_pkg::mid_stage_t mid_q, mid_d;
  logic                  out_valid_q;
  logic [55:0]           out_data_q, out_data_d;

  logic in_fire, mid_adv, out_free;

  logic                    action;
  logic [CountW-1:0]       count_a, count_b;
  logic signed [DistW-1:0] target_a, target_b;
  wheel_upd_t              upd_a, upd_b;
  logic signed [DistW-1:0] rem_a_d, rem_b_d;
  dwepd_pkg::heading_e     head_a_d, head_b_d;
  logic [DutyW-1:0]        duty_a, duty_b;

  assign action   = s_axis_tuser;
  assign count_a  = s_axis_tdata[15:0];
  assign count_b  = s_axis_tdata[31:16];
  assign target_a = s_axis_tdata[47:32];
  assign target_b = s_axis_tdata[63:48];

  // The output register frees when empty or being taken; the middle stage moves into it then.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign mid_adv       = mid_valid_q && out_free;
  assign s_axis_tready = !mid_valid_q || out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Tick update for one wheel: count change with wrap handling, move toward zero,
  // saturate to 16 bits, and take the forward limit pair only when the old distance is positive.
  function automatic wheel_upd_t wheel_update(
    input logic signed [DistW-1:0] rem,
    input logic [CountW-1:0]       prev,
    input dwepd_pkg::heading_e     head,
    input logic [CountW-1:0]       count,
    input logic [GainW-1:0]        gain,
    input logic [LimW-1:0]         limits
  );
    wheel_upd_t              res;
    logic [CountW-1:0]       diff;
    logic signed [DistW+2:0] sum;
    logic signed [DistW-1:0] sat;
    logic                    fwd;
    diff = (count >= prev) ? (count - prev) : (prev - count);
    // Above the wrap limit the change is 65536 minus the change, which is its negation mod 2^16.
    if (diff > dwepd_pkg::WrapLimit) begin
      diff = CountW'(~diff + CountW'(1));
    end
    fwd      = (rem > 0);
    res.head = head;
    sum      = (DistW+3)'(rem);
    if (fwd) begin
      res.head = dwepd_pkg::HEAD_FWD;
      sum      = (DistW+3)'(rem) - $signed({3'b000, diff});
    end else if (rem < 0) begin
      res.head = dwepd_pkg::HEAD_BACK;
      sum      = (DistW+3)'(rem) + $signed({3'b000, diff});
    end
    if (sum > (DistW+3)'(32767)) begin
      sat = 16'sh7FFF;
    end else if (sum < -(DistW+3)'(32768)) begin
      sat = 16'sh8000;
    end else begin
      sat = sum[DistW-1:0];
    end
    res.rem        = sat;
    res.stage.mag  = sat[DistW-1] ? MagW'(-(MagW'($signed(sat)))) : MagW'(sat);
    res.stage.gain = gain;
    res.stage.lo   = fwd ? limits[7:0]  : limits[23:16];
    res.stage.hi   = fwd ? limits[15:8] : limits[31:24];
    return res;
  endfunction

  // Duty from the exact Q16 product: zero on load or below 0.01, then minimum test, then maximum.
  function automatic logic [DutyW-1:0] wheel_duty(
    input dwepd_pkg::wheel_stage_t st,
    input logic                    load
  );
    logic [ProdW-1:0]       prod;
    logic [ProdW-16-1:0]    whole;
    logic [DutyW-1:0]       duty;
    prod  = ProdW'(st.mag) * ProdW'(st.gain);
    whole = prod[ProdW-1:16];
    if (load || prod < dwepd_pkg::MinProduct) begin
      duty = '0;
    end else if (whole < (ProdW-16)'(st.lo)) begin
      duty = st.lo;
    end else if (whole > (ProdW-16)'(st.hi) ||
                 (whole == (ProdW-16)'(st.hi) && prod[15:0] != '0)) begin
      duty = st.hi;
    end else begin
      duty = whole[DutyW-1:0];
    end
    return duty;
  endfunction

  assign upd_a = wheel_update(remaining_a_q, prev_count_a_q, heading_a_q, count_a,
                              gain_a_q, limits_a_q);
  assign upd_b = wheel_update(remaining_b_q, prev_count_b_q, heading_b_q, count_b,
                              gain_b_q, limits_b_q);

  // A load takes the new targets and keeps the headings; a tick takes the updated values.
  always_comb begin
    if (action) begin
      rem_a_d  = target_a;
      rem_b_d  = target_b;
      head_a_d = heading_a_q;
      head_b_d = heading_b_q;
    end else begin
      rem_a_d  = upd_a.rem;
      rem_b_d  = upd_b.rem;
      head_a_d = upd_a.head;
      head_b_d = upd_b.head;
    end
    mid_d.load     = action;
    mid_d.wa       = upd_a.stage;
    mid_d.wb       = upd_b.stage;
    mid_d.dir_a    = head_a_d;
    mid_d.dir_b    = head_b_d;
    mid_d.left_a   = rem_a_d;
    mid_d.left_b   = rem_b_d;
    mid_d.arrived  = (rem_a_d == '0) && (rem_b_d == '0);
  end

  assign duty_a = wheel_duty(mid_q.wa, mid_q.load);
  assign duty_b = wheel_duty(mid_q.wb, mid_q.load);

  always_comb begin
    out_data_d = {1'b0, mid_q.arrived, mid_q.left_b, mid_q.left_a,
                  (duty_b == '0), (duty_a == '0),
                  mid_q.dir_b, mid_q.dir_a, duty_b, duty_a};
  end

  // Configuration writes land directly; the user must write only while idle; it is not enforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_a_q   <= dwepd_pkg::GainReset;
      gain_b_q   <= dwepd_pkg::GainReset;
      limits_a_q <= dwepd_pkg::LimAReset;
      limits_b_q <= dwepd_pkg::LimBReset;
    end else if (cfg_we_i) begin
      unique case (dwepd_pkg::cfg_idx_e'(cfg_idx_i))
        dwepd_pkg::CFG_GAIN_A:   gain_a_q   <= cfg_data_i[GainW-1:0];
        dwepd_pkg::CFG_GAIN_B:   gain_b_q   <= cfg_data_i[GainW-1:0];
        dwepd_pkg::CFG_LIMITS_A: limits_a_q <= cfg_data_i;
        dwepd_pkg::CFG_LIMITS_B: limits_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // State moves at the accepting edge, so the next transaction sees it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_a_q  <= '0;
      remaining_b_q  <= '0;
      prev_count_a_q <= '0;
      prev_count_b_q <= '0;
      heading_a_q    <= dwepd_pkg::HEAD_NONE;
      heading_b_q    <= dwepd_pkg::HEAD_NONE;
    end else if (in_fire) begin
      remaining_a_q  <= rem_a_d;
      remaining_b_q  <= rem_b_d;
      prev_count_a_q <= count_a;
      prev_count_b_q <= count_b;
      heading_a_q    <= head_a_d;
      heading_b_q    <= head_b_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        mid_valid_q <= 1'b1;
      end else if (mid_adv) begin
        mid_valid_q <= 1'b0;
      end
      if (mid_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mid_q <= mid_d;
    end
    if (mid_adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
